>>> rtl/dtsep_pkg.sv
// ----------------------------------------------------------------------------
// dtsep_pkg
// shared types, constants and control word layout for the decimal formatter
// ----------------------------------------------------------------------------
package dtsep_pkg;

	localparam int unsigned VALUE_W    = 64;
	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned DIGITS     = 20;
	localparam int unsigned BCD_W      = 4 * DIGITS;
	localparam int unsigned BITS_STEP  = 4;
	localparam int unsigned CONV_STEPS = VALUE_W / BITS_STEP;
	localparam int unsigned CNT_W      = $clog2(CONV_STEPS);
	localparam int unsigned LEFT_W     = $clog2(DIGITS + 1);
	localparam int unsigned PC_W       = 3;

	localparam logic [CHAR_W-1:0] ASCII_ZERO_HI = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_COMMA   = 8'h2C;

	typedef logic [PC_W-1:0] pc_t;

	// program step addresses
	localparam pc_t PC_IDLE  = 3'd0;
	localparam pc_t PC_CONV  = 3'd1;
	localparam pc_t PC_SKIP  = 3'd2;
	localparam pc_t PC_DIGIT = 3'd3;
	localparam pc_t PC_COMMA = 3'd4;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_DABBLE,
		OP_SKIP,
		OP_EMIT
	} op_t;

	typedef enum logic [1:0] {
		OUT_NONE,
		OUT_DIGIT,
		OUT_COMMA
	} out_sel_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_INPUT,
		COND_CNT_BUSY,
		COND_LEAD_ZERO,
		COND_DIGIT_HOLD,
		COND_STALL,
		COND_LAST
	} cond_t;

	typedef struct packed {
		logic     in_ready;
		op_t      op;
		out_sel_t out_sel;
		cond_t    hold_cond;
		cond_t    jump_cond;
		pc_t      target;
	} ctl_word_t;

	typedef struct packed {
		logic cnt_busy;
		logic lead_zero;
		logic last;
		logic comma_due;
	} dp_status_t;

	// group position counter, counts down 2,1,0,2,...
	function automatic logic [1:0] mod3_dec(input logic [1:0] m);
		logic [1:0] r;
		r = (m == 2'd0) ? 2'd2 : m - 2'd1;
		return r;
	endfunction

endpackage

>>> rtl/decimal_with_thousands_separator.sv
// ----------------------------------------------------------------------------
// decimal_with_thousands_separator
// formats an unsigned 64-bit number as ascii decimal text with commas
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with a 64-bit value word. a word is
//   taken only while the block is idle; in_stall is high for the rest.
//   output channel: out_valid / out_stall, one ascii character per word,
//   most significant first, last high on the final digit. the leading group
//   has no leading zeros, each later group is a comma and three digits, and
//   zero gives a single "0". at most 26 characters per number.
//   timing: binary to bcd conversion first (four bits a cycle), then a
//   zero-skip pass that shifts the suppressed leading zeros out of the bcd
//   shift register, then the characters while out_stall is low, then back
//   to idle.
//   a stall on the output holds the character and last steady until taken.
//   reset (arst_n low) returns the program counter to idle at once; any
//   number in flight is dropped and nothing is emitted for it.
// ----------------------------------------------------------------------------
module decimal_with_thousands_separator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [dtsep_pkg::VALUE_W-1:0] value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dtsep_pkg::CHAR_W-1:0]  character,
	output logic                          last
);

	dtsep_pkg::pc_t        pc_q;
	dtsep_pkg::pc_t        pc_next;
	dtsep_pkg::ctl_word_t  ctl;
	dtsep_pkg::dp_status_t status;
	logic                  hold;
	logic                  jump;

	// control word for the current step
	dtsep_rom u_rom (
		.pc   (pc_q),
		.word (ctl)
	);

	dtsep_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.value     (value),
		.character (character),
		.last      (last),
		.status    (status)
	);

	assign in_stall  = !ctl.in_ready;
	assign out_valid = (ctl.out_sel != dtsep_pkg::OUT_NONE);

	// condition mux, shared by the hold and jump fields
	function automatic logic eval_cond(
		input dtsep_pkg::cond_t      c,
		input dtsep_pkg::dp_status_t st,
		input logic                  iv,
		input logic                  os
	);
		logic r;
		case (c)
			dtsep_pkg::COND_NEVER:      r = 1'b0;
			dtsep_pkg::COND_ALWAYS:     r = 1'b1;
			dtsep_pkg::COND_NO_INPUT:   r = !iv;
			dtsep_pkg::COND_CNT_BUSY:   r = st.cnt_busy;
			dtsep_pkg::COND_LEAD_ZERO:  r = st.lead_zero;
			// stay on the digit step while stalled, or when the next digit
			// follows in the same group
			dtsep_pkg::COND_DIGIT_HOLD: r = os || (!st.last && !st.comma_due);
			dtsep_pkg::COND_STALL:      r = os;
			dtsep_pkg::COND_LAST:       r = st.last;
			default:                    r = 1'b0;
		endcase
		return r;
	endfunction

	assign hold = eval_cond(ctl.hold_cond, status, in_valid, out_stall);
	assign jump = eval_cond(ctl.jump_cond, status, in_valid, out_stall);

	// sequencer: hold, else jump, else fall through to the next step
	always_comb begin
		if (hold) begin
			pc_next = pc_q;
		end else if (jump) begin
			pc_next = ctl.target;
		end else begin
			pc_next = pc_q + dtsep_pkg::PC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= dtsep_pkg::PC_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	// a comma never ends the text
	a_comma_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && character == dtsep_pkg::ASCII_COMMA) |-> !last)
		else $error("comma flagged as last character");

	// a taken comma is always followed by a digit
	a_comma_then_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && character == dtsep_pkg::ASCII_COMMA) |=>
		(out_valid && character != dtsep_pkg::ASCII_COMMA))
		else $error("comma not followed by a digit");

	// nothing more comes out after the last character is taken
	a_quiet_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last) |=> !out_valid)
		else $error("output valid right after last character");

	// no input taken while characters are still pending
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted while emitting");

	// an accepted number enters conversion and shows no output next cycle
	a_accept_starts_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (!out_valid && status.cnt_busy))
		else $error("conversion did not start after accept");

endmodule

>>> rtl/dtsep_rom.sv
// ----------------------------------------------------------------------------
// dtsep_rom
// microcode store: one control word per program step
// ----------------------------------------------------------------------------
module dtsep_rom (
	input  dtsep_pkg::pc_t       pc,
	output dtsep_pkg::ctl_word_t word
);

	always_comb begin
		case (pc)
			dtsep_pkg::PC_IDLE: begin
				word = '{1'b1, dtsep_pkg::OP_LOAD, dtsep_pkg::OUT_NONE,
					dtsep_pkg::COND_NO_INPUT, dtsep_pkg::COND_NEVER, dtsep_pkg::PC_IDLE};
			end
			dtsep_pkg::PC_CONV: begin
				word = '{1'b0, dtsep_pkg::OP_DABBLE, dtsep_pkg::OUT_NONE,
					dtsep_pkg::COND_CNT_BUSY, dtsep_pkg::COND_NEVER, dtsep_pkg::PC_IDLE};
			end
			dtsep_pkg::PC_SKIP: begin
				word = '{1'b0, dtsep_pkg::OP_SKIP, dtsep_pkg::OUT_NONE,
					dtsep_pkg::COND_LEAD_ZERO, dtsep_pkg::COND_NEVER, dtsep_pkg::PC_IDLE};
			end
			dtsep_pkg::PC_DIGIT: begin
				word = '{1'b0, dtsep_pkg::OP_EMIT, dtsep_pkg::OUT_DIGIT,
					dtsep_pkg::COND_DIGIT_HOLD, dtsep_pkg::COND_LAST, dtsep_pkg::PC_IDLE};
			end
			dtsep_pkg::PC_COMMA: begin
				word = '{1'b0, dtsep_pkg::OP_NONE, dtsep_pkg::OUT_COMMA,
					dtsep_pkg::COND_STALL, dtsep_pkg::COND_ALWAYS, dtsep_pkg::PC_DIGIT};
			end
			default: begin
				word = '{1'b0, dtsep_pkg::OP_NONE, dtsep_pkg::OUT_NONE,
					dtsep_pkg::COND_NEVER, dtsep_pkg::COND_ALWAYS, dtsep_pkg::PC_IDLE};
			end
		endcase
	end

endmodule

>>> rtl/dtsep_datapath.sv
// ----------------------------------------------------------------------------
// dtsep_datapath
// binary to bcd shift register, digit counters and character output
// ----------------------------------------------------------------------------
module dtsep_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dtsep_pkg::ctl_word_t              ctl,
	input  logic                              in_valid,
	input  logic                              out_stall,
	input  logic [dtsep_pkg::VALUE_W-1:0]     value,
	output logic [dtsep_pkg::CHAR_W-1:0]      character,
	output logic                              last,
	output dtsep_pkg::dp_status_t             status
);

	logic [dtsep_pkg::VALUE_W-1:0] bin_q;
	logic [dtsep_pkg::BCD_W-1:0]   bcd_q;
	logic [dtsep_pkg::CNT_W-1:0]   cnt_q;
	logic [dtsep_pkg::LEFT_W-1:0]  left_q;
	logic [1:0]                    mod3_q;

	logic [dtsep_pkg::VALUE_W-1:0] bin_dab;
	logic [dtsep_pkg::BCD_W-1:0]   bcd_dab;
	logic [3:0]                    top_digit;
	logic                          shift_digit;

	// several shift-add-3 steps per cycle
	always_comb begin
		logic [dtsep_pkg::VALUE_W-1:0] b;
		logic [dtsep_pkg::BCD_W-1:0]   d;
		b = bin_q;
		d = bcd_q;
		for (int s = 0; s < dtsep_pkg::BITS_STEP; s++) begin
			for (int k = 0; k < dtsep_pkg::DIGITS; k++) begin
				if (d[4*k +: 4] >= 4'd5) begin
					d[4*k +: 4] = d[4*k +: 4] + 4'd3;
				end
			end
			d = {d[dtsep_pkg::BCD_W-2:0], b[dtsep_pkg::VALUE_W-1]};
			b = {b[dtsep_pkg::VALUE_W-2:0], 1'b0};
		end
		bin_dab = b;
		bcd_dab = d;
	end

	assign top_digit = bcd_q[dtsep_pkg::BCD_W-1 -: 4];

	assign status.cnt_busy  = (cnt_q != '0);
	assign status.lead_zero = (top_digit == 4'd0) && (left_q > dtsep_pkg::LEFT_W'(1));
	assign status.last      = (left_q == dtsep_pkg::LEFT_W'(1));
	assign status.comma_due = (mod3_q == 2'd1);

	always_comb begin
		case (ctl.op)
			dtsep_pkg::OP_SKIP: shift_digit = status.lead_zero;
			dtsep_pkg::OP_EMIT: shift_digit = !out_stall;
			default:            shift_digit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			left_q <= dtsep_pkg::LEFT_W'(1);
			mod3_q <= 2'd1;
		end else begin
			if (ctl.op == dtsep_pkg::OP_LOAD && in_valid) begin
				cnt_q  <= dtsep_pkg::CNT_W'(dtsep_pkg::CONV_STEPS - 1);
				left_q <= dtsep_pkg::LEFT_W'(dtsep_pkg::DIGITS);
				mod3_q <= 2'(dtsep_pkg::DIGITS % 3);
			end else if (ctl.op == dtsep_pkg::OP_DABBLE) begin
				cnt_q <= cnt_q - dtsep_pkg::CNT_W'(1);
			end else if (shift_digit) begin
				left_q <= left_q - dtsep_pkg::LEFT_W'(1);
				mod3_q <= dtsep_pkg::mod3_dec(mod3_q);
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (ctl.op == dtsep_pkg::OP_LOAD && in_valid) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (ctl.op == dtsep_pkg::OP_DABBLE) begin
			bin_q <= bin_dab;
			bcd_q <= bcd_dab;
		end else if (shift_digit) begin
			bcd_q <= {bcd_q[dtsep_pkg::BCD_W-5:0], 4'd0};
		end
	end

	always_comb begin
		case (ctl.out_sel)
			dtsep_pkg::OUT_DIGIT: begin
				character = dtsep_pkg::ASCII_ZERO_HI | {4'd0, top_digit};
				last      = status.last;
			end
			dtsep_pkg::OUT_COMMA: begin
				character = dtsep_pkg::ASCII_COMMA;
				last      = 1'b0;
			end
			default: begin
				character = dtsep_pkg::ASCII_ZERO_HI;
				last      = 1'b0;
			end
		endcase
	end

endmodule
